// ===== rtl/sfas_pkg.sv =====
// shared types and constants for the sawtooth fir audio source
// no dependencies; used by every module of the block except sfas_ram
package sfas_pkg;

  localparam int DATA_W    = 24;
  localparam int IDX_W     = 8;
  localparam int CFG_IDX_W = 8;
  localparam int PROD_W    = 49;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] PHASE_STEP_RESET = DATA_W'(167772);
  localparam int SAT_MAX = 8388607;
  localparam int SAT_MIN = -8388608;

  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_COEF_WRITE = 1'b1;

  typedef struct packed {
    logic                     op;
    logic                     silence;
    logic [IDX_W-1:0]         coef_index;
    logic signed [DATA_W-1:0] coef_value;
  } sfas_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_left;
    logic signed [DATA_W-1:0] out_right;
  } sfas_out_t;

  typedef struct packed {
    logic             clear;
    logic             coef_wr;
    logic             start;
    logic             issue;
    logic             load_out;
    logic             zero_out;
    logic             advance;
    logic [IDX_W-1:0] k;
  } sfas_cmd_t;

  typedef struct packed {
    logic run_enable;
    logic coef_ok;
  } sfas_status_t;

endpackage

// ===== rtl/sfas_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module sfas_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 115
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sfas_ctrl.sv =====
// sequencer: clearing pass, request decode, tap loop and result handoff
// depends on sfas_pkg
module sfas_ctrl #(
  parameter int TAPS = 115
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sfas_pkg::sfas_in_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  sfas_pkg::sfas_status_t status,
  output sfas_pkg::sfas_cmd_t    cmd
);

  localparam int KW = sfas_pkg::IDX_W + 1;
  localparam logic [KW-1:0] K_LAST = KW'(TAPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DRAIN_A,
    S_DRAIN_B,
    S_RESULT
  } state_t;

  state_t                       state_r;
  logic [sfas_pkg::IDX_W-1:0]   k_r;
  logic                         out_valid_r;
  logic                         zero_r;
  logic                         accept;
  logic                         k_last;
  logic                         load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_ready && in_valid;
  assign k_last    = ({1'b0, k_r} == K_LAST);
  assign load_out  = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.k        = k_r;
    cmd.clear    = (state_r == S_CLEAR);
    cmd.coef_wr  = accept && (in_data.op == sfas_pkg::OP_COEF_WRITE) && status.coef_ok;
    cmd.start    = accept && (in_data.op == sfas_pkg::OP_TICK) && status.run_enable
                   && !in_data.silence;
    cmd.issue    = (state_r == S_MAC);
    cmd.load_out = load_out;
    cmd.zero_out = zero_r;
    cmd.advance  = load_out && !zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      zero_r      <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (k_last) begin
            k_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept && (in_data.op == sfas_pkg::OP_TICK) && status.run_enable) begin
            zero_r  <= in_data.silence;
            k_r     <= '0;
            state_r <= in_data.silence ? S_RESULT : S_MAC;
          end
        end
        S_MAC: begin
          if (k_last) begin
            state_r <= S_DRAIN_A;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DRAIN_A: begin
          state_r <= S_DRAIN_B;
        end
        S_DRAIN_B: begin
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sfas_dp.sv =====
// datapath: config registers, phase accumulator, tap memories, mac and output
// depends on sfas_pkg and sfas_ram
module sfas_dp #(
  parameter int TAPS = 115
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [sfas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfas_pkg::DATA_W-1:0]          cfg_data,
  input  sfas_pkg::sfas_in_t                   in_data,
  input  sfas_pkg::sfas_cmd_t                  cmd,
  output sfas_pkg::sfas_status_t               status,
  output sfas_pkg::sfas_out_t                  out_data
);

  localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int KW     = sfas_pkg::IDX_W + 1;
  localparam int DW     = sfas_pkg::DATA_W;
  localparam int PROD_W = sfas_pkg::PROD_W;
  localparam int ACC_W  = PROD_W + AW + 1;
  localparam int QW     = ACC_W - 24;
  localparam logic [KW-1:0]         TAPS_K = KW'(TAPS);
  localparam logic [AW:0]           TAPS_A = (AW + 1)'(TAPS);
  localparam logic [AW-1:0]         WPTR_TOP = AW'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(8388608);
  localparam logic signed [QW-1:0]  Q_MAX = QW'(sfas_pkg::SAT_MAX);
  localparam logic signed [QW-1:0]  Q_MIN = QW'(sfas_pkg::SAT_MIN);

  logic [DW-1:0]              step_r;
  logic                       run_r;
  logic [DW-1:0]              phase_r;
  logic [AW-1:0]              wptr_r;
  logic                       v1_r;
  logic                       v2_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  sfas_pkg::sfas_out_t        out_r;

  logic          d_we;
  logic [AW-1:0] d_waddr;
  logic [DW-1:0] d_wdata;
  logic [AW-1:0] d_raddr;
  logic [DW-1:0] d_rdata;
  logic          c_we;
  logic [AW-1:0] c_waddr;
  logic [DW-1:0] c_wdata;
  logic [DW-1:0] c_rdata;
  logic [AW:0]   tap_sum;
  logic signed [ACC_W-1:0] rnd;
  logic signed [QW-1:0]    q;
  logic [DW-1:0]           sample;

  assign status.run_enable = run_r;
  assign status.coef_ok    = ({1'b0, in_data.coef_index} < TAPS_K);
  assign out_data          = out_r;

  assign d_we    = cmd.clear || cmd.start;
  assign d_waddr = cmd.clear ? cmd.k[AW-1:0] : wptr_r;
  assign d_wdata = cmd.clear ? '0 : phase_r;
  assign c_we    = cmd.clear || cmd.coef_wr;
  assign c_waddr = cmd.clear ? cmd.k[AW-1:0] : in_data.coef_index[AW-1:0];
  assign c_wdata = cmd.clear ? '0 : in_data.coef_value;

  // tap k of the delay line sits k entries past the write pointer
  assign tap_sum = {1'b0, wptr_r} + {1'b0, cmd.k[AW-1:0]};
  assign d_raddr = (tap_sum >= TAPS_A) ? AW'(tap_sum - TAPS_A) : tap_sum[AW-1:0];

  sfas_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_delay_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  sfas_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (cmd.k[AW-1:0]),
    .rdata (c_rdata)
  );

  // round half up, then saturate to 24 bits
  always_comb begin
    rnd = acc_r + HALF;
    q   = signed'(rnd[ACC_W-1:24]);
    if (q > Q_MAX) begin
      sample = Q_MAX[DW-1:0];
    end else if (q < Q_MIN) begin
      sample = Q_MIN[DW-1:0];
    end else begin
      sample = q[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= sfas_pkg::PHASE_STEP_RESET;
      run_r   <= 1'b0;
      phase_r <= '0;
      wptr_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sfas_pkg::REG_PHASE_STEP: begin
            step_r <= cfg_data;
          end
          sfas_pkg::REG_RUN_ENABLE: begin
            run_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.start) begin
        phase_r <= phase_r + step_r;
      end
      if (cmd.advance) begin
        wptr_r <= (wptr_r == '0) ? WPTR_TOP : wptr_r - 1'b1;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= $signed({1'b0, d_rdata}) * $signed(c_rdata);
    end
    if (cmd.start) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.load_out) begin
      out_r.out_left  <= cmd.zero_out ? '0 : sample;
      out_r.out_right <= cmd.zero_out ? '0 : sample;
    end
  end

endmodule

// ===== rtl/sawtooth_fir_audio_source.sv =====
// sawtooth fir audio source: phase accumulator into a TAPS-tap direct-form fir
// tick runs the tap loop, two drain states and the result state before out_valid, one mac per tap
// next request accepted once the result is handed to the output register, not while a tick is in flight
// silent tick goes straight to the result state and outputs zeros, coefficient write completes on accept
// after reset a clearing pass writes zero to every entry of both tap memories, in_ready low
module sawtooth_fir_audio_source #(
  parameter int TAPS = 115
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfas_pkg::DATA_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sfas_pkg::sfas_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sfas_pkg::sfas_out_t             out_data
);

  sfas_pkg::sfas_cmd_t    cmd;
  sfas_pkg::sfas_status_t status;

  assign cfg_ready = 1'b1;

  sfas_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfas_dp #(.TAPS(TAPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == sfas_pkg::OP_TICK) && status.run_enable
    && !in_data.silence |=> !in_ready)
    else $error("filter tick did not occupy the sequencer");

  a_coef_wr_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == sfas_pkg::OP_COEF_WRITE) |=> in_ready)
    else $error("coefficient write did not complete in one cycle");

  a_mute_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == sfas_pkg::OP_TICK) && !status.run_enable
    |=> in_ready && (out_valid == $past(out_valid && !out_ready)))
    else $error("tick with run disabled produced a result");

  a_channels_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_left == out_data.out_right))
    else $error("left and right samples differ");

endmodule
